// ===== rtl/core/zctd_pkg.sv =====
// ----------------------------------------------------------------------------
// zctd_pkg
// Shared types, constants and the character map of the packed-text decoder.
// ----------------------------------------------------------------------------
package zctd_pkg;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned ADDR_W    = 17;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned BASE_W    = 16;

  localparam logic [COUNT_W-1:0] WORD_LIMIT_RESET = 5'd30;

  // configuration register indexes
  localparam logic REG_WORD_LIMIT  = 1'b0;
  localparam logic REG_ABBREV_BASE = 1'b1;

  // special codes
  localparam logic [CODE_W-1:0] CODE_SPACE   = 5'd0;
  localparam logic [CODE_W-1:0] CODE_ABBR_HI = 5'd3;
  localparam logic [CODE_W-1:0] CODE_SHIFT1  = 5'd4;
  localparam logic [CODE_W-1:0] CODE_FIRST   = 5'd6;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 5'd7;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ABBREV = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ALPH_LOWER = 2'd0,
    ALPH_UPPER = 2'd1,
    ALPH_PUNCT = 2'd2
  } alph_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  ascii;
    logic [ADDR_W-1:0]  addr;
  } lane_res_t;

  // punctuation alphabet, codes 8 to 31
  function automatic logic [CHAR_W-1:0] punct_char(input logic [CODE_W-1:0] c);
    logic [CHAR_W-1:0] ch;
    case (c)
      5'd8:    ch = 7'h30;
      5'd9:    ch = 7'h31;
      5'd10:   ch = 7'h32;
      5'd11:   ch = 7'h33;
      5'd12:   ch = 7'h34;
      5'd13:   ch = 7'h35;
      5'd14:   ch = 7'h36;
      5'd15:   ch = 7'h37;
      5'd16:   ch = 7'h38;
      5'd17:   ch = 7'h39;
      5'd18:   ch = 7'h2E;
      5'd19:   ch = 7'h2C;
      5'd20:   ch = 7'h21;
      5'd21:   ch = 7'h3F;
      5'd22:   ch = 7'h5F;
      5'd23:   ch = 7'h23;
      5'd24:   ch = 7'h27;
      5'd25:   ch = 7'h22;
      5'd26:   ch = 7'h2F;
      5'd27:   ch = 7'h5C;
      5'd28:   ch = 7'h2D;
      5'd29:   ch = 7'h3A;
      5'd30:   ch = 7'h28;
      5'd31:   ch = 7'h29;
      default: ch = 7'h3F;
    endcase
    return ch;
  endfunction

  // character for code 0 or codes 6..31 in the given alphabet
  function automatic logic [CHAR_W-1:0] map_char(input alph_t alph,
                                                 input logic [CODE_W-1:0] c);
    logic [CHAR_W-1:0] ch;
    if (c == CODE_SPACE) begin
      ch = 7'h20;
    end else begin
      unique case (alph)
        ALPH_LOWER: ch = CHAR_W'(c) + 7'd91;
        ALPH_UPPER: ch = CHAR_W'(c) + 7'd59;
        default: begin
          if (c == CODE_FIRST) ch = 7'h20;
          else if (c == CODE_NEWLINE) ch = 7'h0A;
          else ch = punct_char(c);
        end
      endcase
    end
    return ch;
  endfunction

endpackage

// ===== rtl/core/zctd_lane.sv =====
// ----------------------------------------------------------------------------
// zctd_lane
// Decodes one 5-bit code against the incoming shift and abbreviation state.
// ----------------------------------------------------------------------------
module zctd_lane import zctd_pkg::*; (
  input  logic [CODE_W-1:0] code,
  input  alph_t             alph_in,
  input  logic [1:0]        pend_in,
  input  logic [BASE_W-1:0] abbrev_base,
  output logic              emit,
  output lane_res_t         res,
  output alph_t             alph_out,
  output logic [1:0]        pend_out
);

  logic [1:0] bank;

  assign bank = pend_in - 2'd1;

  always_comb begin
    emit      = 1'b0;
    res       = '0;
    res.kind  = KIND_CHAR;
    alph_out  = ALPH_LOWER;
    pend_out  = 2'd0;
    if (pend_in != 2'd0) begin
      // armed abbreviation: this code is the table index
      emit      = 1'b1;
      res.kind  = KIND_ABBREV;
      res.addr  = ADDR_W'(abbrev_base) + ADDR_W'({bank, code, 1'b0});
    end else if (code >= CODE_FIRST || code == CODE_SPACE) begin
      emit      = 1'b1;
      res.ascii = map_char(alph_in, code);
    end else if (code <= CODE_ABBR_HI) begin
      pend_out = code[1:0];
      alph_out = alph_in;
    end else begin
      alph_out = (code == CODE_SHIFT1) ? ALPH_UPPER : ALPH_PUNCT;
    end
  end

endmodule

// ===== rtl/core/zctd_merge.sv =====
// ----------------------------------------------------------------------------
// zctd_merge
// Holds the lane results of one word and sends them out one per transfer.
// ----------------------------------------------------------------------------
module zctd_merge import zctd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lane_res_t           lane_res [NUM_LANES],
  input  logic [NUM_LANES-1:0] lane_mask,
  input  logic                ends,
  output logic                take,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [CHAR_W-1:0]   ascii_char,
  output logic [ADDR_W-1:0]   abbrev_entry_addr,
  output logic                last,
  output logic                string_end
);

  lane_res_t            held [NUM_LANES];
  logic [NUM_LANES-1:0] held_mask;
  logic                 held_end;

  logic [NUM_LANES-1:0] pick;
  logic [NUM_LANES-1:0] rest;
  logic [1:0]           pick_idx;
  logic                 advance;

  // lowest set bit is the earliest remaining result
  always_comb begin
    pick     = held_mask & (~held_mask + NUM_LANES'(1));
    rest     = held_mask & ~pick;
    pick_idx = pick[0] ? 2'd0 : (pick[1] ? 2'd1 : 2'd2);
  end

  assign advance = (|held_mask) && (!out_valid || out_ready);
  assign take    = (held_mask == '0) || (advance && rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        held_mask <= lane_mask;
        held      <= lane_res;
        held_end  <= ends;
      end else if (advance) begin
        held_mask <= rest;
      end
      if (advance) begin
        out_valid         <= 1'b1;
        kind              <= held[pick_idx].kind;
        ascii_char        <= held[pick_idx].ascii;
        abbrev_entry_addr <= held[pick_idx].addr;
        last              <= (rest == '0);
        string_end        <= held_end;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_NONE |-> last)
    else $error("empty word result without last");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_CHAR |-> ascii_char == '0)
    else $error("ascii_char set on non-character result");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !take |-> held_mask != '0)
    else $error("input stalled with empty result buffer");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    load |=> held_mask != '0)
    else $error("accepted word left no result");

endmodule

// ===== rtl/core/zchar_text_decoder.sv =====
// ----------------------------------------------------------------------------
// zchar_text_decoder
// Packed-text word decoder: three code lanes and a result serializer.
// ----------------------------------------------------------------------------
//  channel  | signals                                      | handshake
//  ---------+----------------------------------------------+------------
//  input    | text_word                                    | in_valid/in_ready
//  output   | kind, ascii_char, abbrev_entry_addr, last,   | out_valid/out_ready
//           | string_end                                   |
//  config   | wr_index, wr_data                            | wr_en
//
//  a word is decoded in the cycle it is accepted; its 1 to 3 results leave one
//  per cycle while the output register is not stalled by out_ready
//  the result buffer and the output register allow the next word to be taken
//  in the cycle its predecessor's final result moves to the output register
//  synchronous reset clears shift, abbreviation, word count and both buffers
//  a stalled output holds the result; the input stalls once the buffer is full
// ----------------------------------------------------------------------------
module zchar_text_decoder import zctd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [BASE_W-1:0]  wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  text_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [CHAR_W-1:0]  ascii_char,
  output logic [ADDR_W-1:0]  abbrev_entry_addr,
  output logic               last,
  output logic               string_end
);

  logic [COUNT_W-1:0] word_limit;
  logic [BASE_W-1:0]  abbrev_base;
  alph_t              shift_alphabet;
  logic [1:0]         pending_abbrev;
  logic [COUNT_W-1:0] word_count;

  alph_t                alph  [NUM_LANES+1];
  logic [1:0]           pend  [NUM_LANES+1];
  lane_res_t            res   [NUM_LANES];
  lane_res_t            merged[NUM_LANES];
  logic [NUM_LANES-1:0] emit;
  logic [NUM_LANES-1:0] mask;
  logic [COUNT_W-1:0]   word_count_next;
  logic                 ends;
  logic                 accept;

  assign alph[0] = shift_alphabet;
  assign pend[0] = pending_abbrev;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    zctd_lane u_lane (
      .code        (text_word[WORD_W-2-CODE_W*i -: CODE_W]),
      .alph_in     (alph[i]),
      .pend_in     (pend[i]),
      .abbrev_base (abbrev_base),
      .emit        (emit[i]),
      .res         (res[i]),
      .alph_out    (alph[i+1]),
      .pend_out    (pend[i+1])
    );
  end

  // a word with no emitted code still yields one empty result
  always_comb begin
    merged = res;
    mask   = emit;
    if (emit == '0) begin
      merged[0]      = '0;
      merged[0].kind = KIND_NONE;
      mask           = NUM_LANES'(1);
    end
  end

  assign word_count_next = word_count + COUNT_W'(1);
  assign ends   = text_word[WORD_W-1] || (word_count_next >= word_limit);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_limit     <= WORD_LIMIT_RESET;
      abbrev_base    <= '0;
      shift_alphabet <= ALPH_LOWER;
      pending_abbrev <= 2'd0;
      word_count     <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_WORD_LIMIT:  word_limit  <= wr_data[COUNT_W-1:0];
          REG_ABBREV_BASE: abbrev_base <= wr_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (ends) begin
          shift_alphabet <= ALPH_LOWER;
          pending_abbrev <= 2'd0;
          word_count     <= '0;
        end else begin
          shift_alphabet <= alph[NUM_LANES];
          pending_abbrev <= pend[NUM_LANES];
          word_count     <= word_count_next;
        end
      end
    end
  end

  zctd_merge u_merge (
    .clk               (clk),
    .rst               (rst),
    .load              (accept),
    .lane_res          (merged),
    .lane_mask         (mask),
    .ends              (ends),
    .take              (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .kind              (kind),
    .ascii_char        (ascii_char),
    .abbrev_entry_addr (abbrev_entry_addr),
    .last              (last),
    .string_end        (string_end)
  );

endmodule
